>>> rtl/core/bayer_bilinear_demosaic_top_macros.svh
// Assertion macros used by the demosaic top level.
`ifndef BAYER_BILINEAR_DEMOSAIC_TOP_MACROS_SVH
`define BAYER_BILINEAR_DEMOSAIC_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BBD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define BBD_ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define BBD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define BBD_ASSERT_ALWAYS(label, cond, msg)
`define BBD_ASSERT_IMPLY(label, pre, post, msg)
`define BBD_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

>>> rtl/core/bbd_pkg.sv
`timescale 1ns / 1ps
package bbd_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int SAMPLE_BITS = 12;

  localparam int CFG_BITS   = 12;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  localparam int CNT_BITS   = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
  localparam int CMP_BITS   = ((CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS) + 1;
  localparam int COORD_BITS = 11;
  localparam int CHAN_BITS  = 8;

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FLIP_BOTH    = 2'd2;

  localparam logic [CFG_BITS-1:0] RESET_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_BITS-1:0] RESET_FRAME_HEIGHT = 12'd480;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 3);

  typedef struct packed {
    logic [CFG_BITS-1:0] w;
    logic [CFG_BITS-1:0] h;
    logic                flip;
  } geom_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [ROW_BITS-1:0]    row;
    logic [COL_BITS-1:0]    col;
  } pix_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0]  red;
    logic [CHAN_BITS-1:0]  green;
    logic [CHAN_BITS-1:0]  blue;
    logic [COORD_BITS-1:0] out_row;
    logic [COORD_BITS-1:0] out_column;
    logic                  frame_done;
  } result_t;

endpackage

>>> rtl/core/bbd_ram.sv
`timescale 1ns / 1ps
module bbd_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write to the same entry return the old contents.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[addr];
    end
    if (we) begin
      mem[addr] <= wdata;
    end
  end

endmodule

>>> rtl/core/bbd_window.sv
`timescale 1ns / 1ps
module bbd_window (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s1_valid,
  input  bbd_pkg::pix_t                       s1_pix,
  input  logic [bbd_pkg::SAMPLE_BITS-1:0]     q0,
  input  logic [bbd_pkg::SAMPLE_BITS-1:0]     q1,
  input  bbd_pkg::geom_t                      geom,
  output logic                                s2_valid,
  output logic                                push,
  output bbd_pkg::result_t                    push_item
);
  import bbd_pkg::*;

  logic [SAMPLE_BITS-1:0] taps [9];
  logic [SAMPLE_BITS-1:0] older;
  logic [SAMPLE_BITS-1:0] newer;
  logic [CMP_BITS-1:0]    row_x;
  logic [CMP_BITS-1:0]    col_x;
  logic [CMP_BITS-1:0]    w_x;
  logic [CMP_BITS-1:0]    h_x;
  logic                   hit;

  logic                   s2_hit;
  logic                   s2_i_odd;
  logic                   s2_j_odd;
  logic [COORD_BITS-1:0]  s2_row;
  logic [COORD_BITS-1:0]  s2_col;
  logic                   s2_done;

  logic [SAMPLE_BITS:0]   vert_sum;
  logic [SAMPLE_BITS:0]   horz_sum;
  logic [SAMPLE_BITS+1:0] cross_sum;
  logic [SAMPLE_BITS+1:0] diag_sum;
  logic [SAMPLE_BITS-1:0] ctr;
  logic [SAMPLE_BITS-1:0] vert;
  logic [SAMPLE_BITS-1:0] horz;
  logic [SAMPLE_BITS-1:0] cross_avg;
  logic [SAMPLE_BITS-1:0] diag;
  logic [SAMPLE_BITS-1:0] red_full;
  logic [SAMPLE_BITS-1:0] green_full;
  logic [SAMPLE_BITS-1:0] blue_full;

  // The bank of the current row parity holds the line two above.
  assign older = s1_pix.row[0] ? q1 : q0;
  assign newer = s1_pix.row[0] ? q0 : q1;

  assign row_x = CMP_BITS'(s1_pix.row);
  assign col_x = CMP_BITS'(s1_pix.col);
  assign w_x   = CMP_BITS'(geom.w);
  assign h_x   = CMP_BITS'(geom.h);
  assign hit   = (row_x >= CMP_BITS'(2)) && (col_x >= CMP_BITS'(2)) &&
                 (row_x < h_x) && (col_x < w_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_hit   <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        taps[k] <= '0;
      end
    end else begin
      s2_valid <= s1_valid;
      s2_hit   <= s1_valid && hit;
      if (s1_valid) begin
        taps[0] <= taps[1];
        taps[1] <= taps[2];
        taps[2] <= older;
        taps[3] <= taps[4];
        taps[4] <= taps[5];
        taps[5] <= newer;
        taps[6] <= taps[7];
        taps[7] <= taps[8];
        taps[8] <= s1_pix.sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_i_odd <= ~s1_pix.row[0];
      s2_j_odd <= ~s1_pix.col[0];
      s2_row   <= geom.flip ? COORD_BITS'(h_x - row_x)
                            : COORD_BITS'(row_x - CMP_BITS'(1));
      s2_col   <= geom.flip ? COORD_BITS'(w_x - col_x)
                            : COORD_BITS'(col_x - CMP_BITS'(1));
      s2_done  <= (row_x == h_x - CMP_BITS'(1)) && (col_x == w_x - CMP_BITS'(1));
    end
  end

  assign vert_sum  = {1'b0, taps[1]} + {1'b0, taps[7]};
  assign horz_sum  = {1'b0, taps[3]} + {1'b0, taps[5]};
  assign cross_sum = {1'b0, vert_sum} + {1'b0, horz_sum};
  assign diag_sum  = {2'b00, taps[0]} + {2'b00, taps[2]} +
                     {2'b00, taps[6]} + {2'b00, taps[8]};
  assign ctr       = taps[4];
  assign vert      = vert_sum[SAMPLE_BITS:1];
  assign horz      = horz_sum[SAMPLE_BITS:1];
  assign cross_avg = cross_sum[SAMPLE_BITS+1:2];
  assign diag      = diag_sum[SAMPLE_BITS+1:2];

  always_comb begin
    unique case ({s2_i_odd, s2_j_odd})
      2'b11: begin
        green_full = ctr;
        blue_full  = vert;
        red_full   = horz;
      end
      2'b10: begin
        green_full = cross_avg;
        blue_full  = diag;
        red_full   = ctr;
      end
      2'b01: begin
        green_full = cross_avg;
        blue_full  = ctr;
        red_full   = diag;
      end
      default: begin
        green_full = ctr;
        blue_full  = horz;
        red_full   = vert;
      end
    endcase
  end

  assign push                 = s2_hit;
  assign push_item.red        = red_full[SAMPLE_BITS-1 -: CHAN_BITS];
  assign push_item.green      = green_full[SAMPLE_BITS-1 -: CHAN_BITS];
  assign push_item.blue       = blue_full[SAMPLE_BITS-1 -: CHAN_BITS];
  assign push_item.out_row    = s2_row;
  assign push_item.out_column = s2_col;
  assign push_item.frame_done = s2_done;

endmodule

>>> rtl/core/bayer_bilinear_demosaic_top.sv
`timescale 1ns / 1ps
// Bilinear Bayer demosaic. Raw 12-bit samples enter in raster order on the
// in_valid/in_ready channel, with frame_start marking the first sample of a
// frame. Each interior pixel gives one item on the out_valid/out_ready
// channel carrying 8-bit red, green and blue, its coordinates (mirrored when
// flip_both is set) and frame_done on the last interior pixel of the frame.
// Border pixels give no item. Frame size and flip are written through the
// cfg channel; the user must write them only while the block is idle, as
// the block itself does not enforce it. cfg_ready is always high. Throughput
// is one sample per cycle while in_ready is high, set by the two line
// memories, which are both read and one of them written per sample.
// For the sample completing its 3x3 neighbourhood the line memory read
// registers, the window shifts and the interpolated item enters the queue.
// A four-item output queue absorbs stalls; in_ready falls only when the
// queue together with the items still in the pipeline would fill it.
// Reset sets 640 by 480, no flip, empties the pipeline and the queue and
// clears the position counters; the line memories need no clearing.
module bayer_bilinear_demosaic_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [11:0]                          raw_sample,
  input  logic                                 frame_start,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           red,
  output logic [7:0]                           green,
  output logic [7:0]                           blue,
  output logic [10:0]                          out_row,
  output logic [10:0]                          out_column,
  output logic                                 frame_done,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bbd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [11:0]                          cfg_data
);
  import bbd_pkg::*;

`include "bayer_bilinear_demosaic_top_macros.svh"

  logic [CFG_BITS-1:0] frame_width;
  logic [CFG_BITS-1:0] frame_height;
  logic                flip_both;
  geom_t               geom;

  logic [ROW_BITS-1:0] row_count;
  logic [COL_BITS-1:0] column_count;
  logic [ROW_BITS-1:0] row_cur;
  logic [COL_BITS-1:0] col_cur;
  logic [CMP_BITS-1:0] col_inc;
  logic [CMP_BITS-1:0] row_inc;
  logic                col_wrap;
  logic                row_wrap;
  logic                in_fire;

  logic [SAMPLE_BITS-1:0] q0;
  logic [SAMPLE_BITS-1:0] q1;
  logic                   s1_valid;
  pix_t                   s1_pix;
  logic                   s2_valid;
  logic                   push;
  result_t                push_item;

  result_t                  fifo [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr;
  logic [FIFO_PTR_BITS-1:0] rd_ptr;
  logic [FIFO_CNT_BITS-1:0] count;
  logic [FIFO_CNT_BITS-1:0] credit;
  logic                     pop;
  result_t                  head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_FRAME_WIDTH;
      frame_height <= RESET_FRAME_HEIGHT;
      flip_both    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_FLIP_BOTH:    flip_both    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign geom.w    = (int'(frame_width) > MAX_WIDTH) ? CFG_BITS'(MAX_WIDTH) : frame_width;
  assign geom.h    = (int'(frame_height) > MAX_HEIGHT) ? CFG_BITS'(MAX_HEIGHT)
                                                       : frame_height;
  assign geom.flip = flip_both;

  assign in_fire  = in_valid && in_ready;
  assign row_cur  = frame_start ? '0 : row_count;
  assign col_cur  = frame_start ? '0 : column_count;
  assign col_inc  = CMP_BITS'(col_cur) + CMP_BITS'(1);
  assign row_inc  = CMP_BITS'(row_cur) + CMP_BITS'(1);
  assign col_wrap = (col_inc >= CMP_BITS'(geom.w)) || (col_inc >= CMP_BITS'(MAX_WIDTH));
  assign row_wrap = (row_inc >= CMP_BITS'(geom.h)) || (row_inc >= CMP_BITS'(MAX_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= '0;
      column_count <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= in_fire;
      if (in_fire) begin
        if (col_wrap) begin
          column_count <= '0;
          row_count    <= row_wrap ? '0 : row_inc[ROW_BITS-1:0];
        end else begin
          column_count <= col_inc[COL_BITS-1:0];
          row_count    <= row_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix.sample <= raw_sample[SAMPLE_BITS-1:0];
      s1_pix.row    <= row_cur;
      s1_pix.col    <= col_cur;
    end
  end

  bbd_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line_even (
    .clk  (clk),
    .en   (in_fire),
    .we   (in_fire && !row_cur[0]),
    .addr (col_cur),
    .wdata(raw_sample[SAMPLE_BITS-1:0]),
    .rdata(q0)
  );

  bbd_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line_odd (
    .clk  (clk),
    .en   (in_fire),
    .we   (in_fire && row_cur[0]),
    .addr (col_cur),
    .wdata(raw_sample[SAMPLE_BITS-1:0]),
    .rdata(q1)
  );

  bbd_window u_window (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_pix   (s1_pix),
    .q0       (q0),
    .q1       (q1),
    .geom     (geom),
    .s2_valid (s2_valid),
    .push     (push),
    .push_item(push_item)
  );

  // Every item in flight reserves a queue slot, so a push always finds room.
  assign credit   = count + FIFO_CNT_BITS'(s1_valid) + FIFO_CNT_BITS'(s2_valid);
  assign in_ready = credit < FIFO_CNT_BITS'(FIFO_DEPTH);

  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign head      = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_BITS'(1);
      end
      count <= count + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= push_item;
    end
  end

  assign red        = head.red;
  assign green      = head.green;
  assign blue       = head.blue;
  assign out_row    = head.out_row;
  assign out_column = head.out_column;
  assign frame_done = head.frame_done;

  `BBD_ASSERT_ALWAYS(a_credit_bound, credit <= FIFO_CNT_BITS'(FIFO_DEPTH), "queue credit overrun")
  `BBD_ASSERT_IMPLY(a_push_room, push, count < FIFO_CNT_BITS'(FIFO_DEPTH) || pop, "push into full queue")
  `BBD_ASSERT_NEXT(a_frame_origin, in_fire && frame_start, s1_pix.row == '0 && s1_pix.col == '0, "frame start not at origin")

endmodule
